// ===== design/sdh_pkg.sv =====
// Package for the SD card SPI host engine: word types, phase codes, constants.
// No dependencies.
package sdh_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int WAKE_BYTES  = 10;
    localparam int BIDX_W      = 10;

    localparam logic [2:0] MODE_INIT = 3'd0;
    localparam logic [2:0] MODE_READ = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_XCHG = 3'd3;
    localparam logic [2:0] MODE_TICK = 3'd4;

    localparam logic [2:0] REG_READY_TO = 3'd0;
    localparam logic [2:0] REG_INIT_TO  = 3'd1;
    localparam logic [2:0] REG_TOKEN_TO = 3'd2;
    localparam logic [2:0] REG_BUSY_TO  = 3'd3;
    localparam logic [2:0] REG_TRIES    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INIT_ERR = 2'd1;
    localparam logic [1:0] ST_XFER_ERR = 2'd2;

    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_IF_COND   = 6'd8;
    localparam logic [5:0] CMD_STOP      = 6'd12;
    localparam logic [5:0] CMD_RD_SINGLE = 6'd17;
    localparam logic [5:0] CMD_RD_MULTI  = 6'd18;
    localparam logic [5:0] CMD_WR_SINGLE = 6'd24;
    localparam logic [5:0] CMD_WR_MULTI  = 6'd25;
    localparam logic [5:0] CMD_OP_COND   = 6'd41;
    localparam logic [5:0] CMD_APP       = 6'd55;
    localparam logic [5:0] CMD_READ_OCR  = 6'd58;

    typedef enum logic [19:0] {
        PH_IDLE  = 20'h00001, PH_WAKE  = 20'h00002, PH_RDY   = 20'h00004,
        PH_CMD   = 20'h00008, PH_R1    = 20'h00010, PH_X0    = 20'h00020,
        PH_R4    = 20'h00040, PH_X8    = 20'h00080, PH_X41   = 20'h00100,
        PH_TOK   = 20'h00200, PH_RD    = 20'h00400, PH_RCRC  = 20'h00800,
        PH_XEND  = 20'h01000, PH_WTOK  = 20'h02000, PH_WR    = 20'h04000,
        PH_WCRC  = 20'h08000, PH_DRESP = 20'h10000, PH_BUSY  = 20'h20000,
        PH_STOP  = 20'h40000, PH_FBUSY = 20'h80000
    } t_phase;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] sector;
        logic [31:0] block_count;
        logic [7:0]  rx_byte;
        logic [7:0]  wr_data;
    } t_in_word;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       cs_active;
        logic       wr_data_taken;
        logic [7:0] rd_data;
        logic       rd_valid;
        logic       rd_block_end;
        logic       done_res;
        logic [1:0] status;
        logic       high_capacity;
        logic       initialized;
        logic       engine_busy;
    } t_out_word;

    typedef struct packed {
        logic [15:0] ready_to;
        logic [15:0] init_to;
        logic [15:0] token_to;
        logic [15:0] busy_to;
        logic [7:0]  tries;
    } t_cfg;

endpackage

// ===== design/sd_card_spi_host_engine.sv =====
// Top level of the SD card SPI-mode host engine.
// Depends on sdh_pkg, sdh_cfg_regs, sdh_core.
//
// Every input word (request, exchanged byte or millisecond tick) is one
// step of the protocol sequencer and yields exactly one result word. The
// step is combinational logic from the state registers into the result
// register, so a word is accepted while the previous result is taken: the
// rate is one word per cycle unless the output is stalled with its register
// full. Configuration writes are taken any time; ready is always high.
module sd_card_spi_host_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sdh_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output sdh_pkg::t_out_word o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import sdh_pkg::*;

    t_cfg      cfg;
    t_out_word core_word;
    t_out_word r_out;
    logic      r_out_valid;
    logic      step, core_idle;

    assign o_cfg_ready = 1'b1;
    assign o_stall = r_out_valid && i_stall;
    assign step    = i_valid && !o_stall;

    sdh_cfg_regs u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(i_cfg_valid),
        .i_idx(i_cfg_index), .i_data(i_cfg_data), .o_cfg(cfg)
    );

    sdh_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_word(i_data),
        .i_cfg(cfg), .o_word(core_word), .o_idle(core_idle)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) r_out <= core_word;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // a done word leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && core_word.done_res |=> core_idle)
        else $error("done without idle");

    // busy flag matches sequencer state
    a_busy_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> (r_out.engine_busy == !core_idle))
        else $error("busy flag mismatch");

    // no data byte and done together
    a_rd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> !(core_word.rd_valid && core_word.done_res))
        else $error("read byte with done");
endmodule

// ===== design/sdh_cfg_regs.sv =====
// Configuration register file of the SD host engine.
// Depends on sdh_pkg.
module sdh_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [2:0]    i_idx,
    input  logic [31:0]   i_data,
    output sdh_pkg::t_cfg o_cfg
);
    import sdh_pkg::*;

    t_cfg r_cfg;

    // register writes by index; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ready_to <= 16'd500;
            r_cfg.init_to  <= 16'd1000;
            r_cfg.token_to <= 16'd200;
            r_cfg.busy_to  <= 16'd500;
            r_cfg.tries    <= 8'd255;
        end else if (i_we) begin
            unique case (i_idx)
                REG_READY_TO: r_cfg.ready_to <= i_data[15:0];
                REG_INIT_TO:  r_cfg.init_to  <= i_data[15:0];
                REG_TOKEN_TO: r_cfg.token_to <= i_data[15:0];
                REG_BUSY_TO:  r_cfg.busy_to  <= i_data[15:0];
                REG_TRIES:    r_cfg.tries    <= i_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== design/sdh_core.sv =====
// Protocol sequencer: one step per input word, produces the result word.
// Depends on sdh_pkg.
module sdh_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  sdh_pkg::t_in_word  i_word,
    input  sdh_pkg::t_cfg      i_cfg,
    output sdh_pkg::t_out_word o_word,
    output logic               o_idle
);
    import sdh_pkg::*;

    t_phase        r_phase, n_phase;
    logic [BIDX_W-1:0] r_bidx, n_bidx;
    logic [31:0]   r_addr, n_addr, r_left, n_left, r_arg, n_arg, r_reply, n_reply;
    logic [5:0]    r_cidx, n_cidx;
    logic [7:0]    r_last, n_last, r_poll, n_poll;
    logic [15:0]   r_ms, n_ms, r_ims, n_ims;
    logic          r_ba, n_ba, r_rdy, n_rdy;
    t_out_word     res;
    logic [7:0]    rx;
    logic [31:0]   addr_calc;

    assign o_idle = (r_phase == PH_IDLE);
    assign rx     = i_word.rx_byte;
    assign addr_calc = r_ba ? i_word.sector : {i_word.sector[22:0], 9'd0};

    function automatic logic [7:0] cmd_byte(input logic [2:0] k, input logic [5:0] ci,
                                            input logic [31:0] arg);
        logic [7:0] b;
        b = 8'hFF;
        unique case (k)
            3'd0: b = {2'b01, ci};
            3'd1: b = arg[31:24];
            3'd2: b = arg[23:16];
            3'd3: b = arg[15:8];
            3'd4: b = arg[7:0];
            default: b = (ci == CMD_GO_IDLE) ? 8'h95 : (ci == CMD_IF_COND) ? 8'h87 : 8'hFF;
        endcase
        return b;
    endfunction

    // one step of the sequencer
    always_comb begin
        logic [5:0]  sc_idx;
        logic [31:0] sc_arg;
        logic        do_start, do_after;
        logic [BIDX_W-1:0] bi1;
        n_phase = r_phase; n_bidx = r_bidx; n_addr = r_addr; n_left = r_left;
        n_arg = r_arg; n_reply = r_reply; n_cidx = r_cidx; n_last = r_last;
        n_poll = r_poll; n_ms = r_ms; n_ims = r_ims; n_ba = r_ba; n_rdy = r_rdy;
        res = '0;
        sc_idx = '0; sc_arg = '0; do_start = 1'b0; do_after = 1'b0;
        bi1 = r_bidx + 1'b1;
        if (i_step) begin
            if (i_word.mode == MODE_INIT && r_phase == PH_IDLE) begin
                n_rdy = 1'b0; n_ba = 1'b0; n_phase = PH_WAKE; n_bidx = BIDX_W'(1);
                res.tx_byte = 8'hFF; res.tx_valid = 1'b1;
            end else if ((i_word.mode == MODE_READ || i_word.mode == MODE_WRITE)
                         && r_phase == PH_IDLE) begin
                if (!r_rdy || i_word.block_count == '0) begin
                    res.done_res = 1'b1; res.status = ST_XFER_ERR;
                end else begin
                    n_addr = addr_calc; n_left = i_word.block_count;
                    do_start = 1'b1; sc_arg = addr_calc;
                    if (i_word.block_count == 32'd1)
                        sc_idx = (i_word.mode == MODE_WRITE) ? CMD_WR_SINGLE : CMD_RD_SINGLE;
                    else
                        sc_idx = (i_word.mode == MODE_WRITE) ? CMD_WR_MULTI : CMD_RD_MULTI;
                end
            end else if (i_word.mode == MODE_XCHG && r_phase != PH_IDLE) begin
                unique case (r_phase)
                    PH_WAKE: begin
                        if (r_bidx < BIDX_W'(WAKE_BYTES)) begin
                            n_bidx = bi1; res.tx_byte = 8'hFF; res.tx_valid = 1'b1;
                        end else begin
                            do_start = 1'b1; sc_idx = CMD_GO_IDLE;
                        end
                    end
                    PH_RDY: begin
                        if (rx == 8'hFF) begin
                            n_phase = PH_CMD; n_bidx = '0;
                            res.tx_byte = cmd_byte(3'd0, r_cidx, r_arg);
                            res.tx_valid = 1'b1; res.cs_active = 1'b1;
                        end else if (r_ms == '0) begin
                            n_last = 8'hFF; do_after = 1'b1;
                        end else begin
                            res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.cs_active = 1'b1;
                        end
                    end
                    PH_CMD: begin
                        res.tx_valid = 1'b1; res.cs_active = 1'b1;
                        if (r_bidx < BIDX_W'(5)) begin
                            n_bidx = bi1;
                            res.tx_byte = cmd_byte(bi1[2:0], r_cidx, r_arg);
                        end else begin
                            n_poll = i_cfg.tries; n_phase = PH_R1; res.tx_byte = 8'hFF;
                        end
                    end
                    PH_R1: begin
                        n_poll = r_poll - 1'b1;
                        if (rx[7] && n_poll != '0) begin
                            res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.cs_active = 1'b1;
                        end else begin
                            n_last = rx; do_after = 1'b1;
                        end
                    end
                    PH_X0: begin
                        if (r_last != 8'h01) begin
                            n_phase = PH_IDLE; res.done_res = 1'b1; res.status = ST_INIT_ERR;
                        end else begin
                            do_start = 1'b1; sc_idx = CMD_IF_COND; sc_arg = 32'h0000_01AA;
                        end
                    end
                    PH_R4: begin
                        n_reply = {r_reply[23:0], rx};
                        n_bidx = bi1;
                        if (bi1 < BIDX_W'(4)) begin
                            res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.cs_active = 1'b1;
                        end else if (r_cidx == CMD_IF_COND) begin
                            n_phase = PH_X8; res.tx_byte = 8'hFF; res.tx_valid = 1'b1;
                        end else begin
                            n_ba = n_reply[30]; n_rdy = 1'b1;
                            n_phase = PH_IDLE; res.done_res = 1'b1; res.status = ST_OK;
                        end
                    end
                    PH_X8: begin
                        n_ims = i_cfg.init_to;
                        n_addr = (r_last == 8'h01 && r_reply[15:0] == 16'h01AA)
                                 ? 32'h4000_0000 : 32'h0;
                        do_start = 1'b1; sc_idx = CMD_APP;
                    end
                    PH_X41: begin
                        if (r_last == 8'h00) begin
                            if (r_addr != '0) begin
                                do_start = 1'b1; sc_idx = CMD_READ_OCR;
                            end else begin
                                n_rdy = 1'b1; n_phase = PH_IDLE;
                                res.done_res = 1'b1; res.status = ST_OK;
                            end
                        end else if (r_ims == '0) begin
                            n_phase = PH_IDLE; res.done_res = 1'b1; res.status = ST_INIT_ERR;
                        end else begin
                            do_start = 1'b1; sc_idx = CMD_APP;
                        end
                    end
                    PH_TOK: begin
                        if (rx == 8'hFE) begin
                            n_phase = PH_RD; n_bidx = '0;
                            res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.cs_active = 1'b1;
                        end else if (r_ms == '0) begin
                            n_phase = PH_IDLE; res.done_res = 1'b1; res.status = ST_XFER_ERR;
                        end else begin
                            res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.cs_active = 1'b1;
                        end
                    end
                    PH_RD: begin
                        res.rd_data = rx; res.rd_valid = 1'b1;
                        res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.cs_active = 1'b1;
                        n_bidx = bi1;
                        if (r_bidx == BIDX_W'(BLOCK_BYTES - 1)) begin
                            res.rd_block_end = 1'b1; n_phase = PH_RCRC; n_bidx = '0;
                        end
                    end
                    PH_RCRC: begin
                        if (r_bidx == '0) begin
                            n_bidx = BIDX_W'(1);
                            res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.cs_active = 1'b1;
                        end else begin
                            n_left = r_left - 1'b1;
                            if (r_cidx == CMD_RD_SINGLE) begin
                                n_phase = PH_XEND; res.tx_byte = 8'hFF; res.tx_valid = 1'b1;
                            end else if (n_left != '0) begin
                                n_ms = i_cfg.token_to; n_phase = PH_TOK;
                                res.tx_byte = 8'hFF; res.tx_valid = 1'b1;
                                res.cs_active = 1'b1;
                            end else begin
                                do_start = 1'b1; sc_idx = CMD_STOP;
                            end
                        end
                    end
                    PH_XEND: begin
                        n_phase = PH_IDLE; res.done_res = 1'b1; res.status = ST_OK;
                    end
                    PH_WTOK: begin
                        n_phase = PH_WR; n_bidx = BIDX_W'(1);
                        res.tx_byte = i_word.wr_data; res.tx_valid = 1'b1;
                        res.cs_active = 1'b1; res.wr_data_taken = 1'b1;
                    end
                    PH_WR: begin
                        res.tx_valid = 1'b1; res.cs_active = 1'b1;
                        if (r_bidx < BIDX_W'(BLOCK_BYTES)) begin
                            n_bidx = bi1; res.tx_byte = i_word.wr_data;
                            res.wr_data_taken = 1'b1;
                        end else begin
                            n_phase = PH_WCRC; n_bidx = '0; res.tx_byte = 8'hFF;
                        end
                    end
                    PH_WCRC: begin
                        if (r_bidx == '0) n_bidx = BIDX_W'(1);
                        else n_phase = PH_DRESP;
                        res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.cs_active = 1'b1;
                    end
                    PH_DRESP: begin
                        if (rx[4:0] != 5'h05) begin
                            n_phase = PH_IDLE; res.done_res = 1'b1; res.status = ST_XFER_ERR;
                        end else begin
                            n_phase = PH_BUSY; n_ms = i_cfg.busy_to;
                            res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.cs_active = 1'b1;
                        end
                    end
                    PH_BUSY: begin
                        res.tx_valid = 1'b1; res.cs_active = 1'b1; res.tx_byte = 8'hFF;
                        if (!(rx == 8'h00 && r_ms != '0)) begin
                            n_left = r_left - 1'b1;
                            if (r_cidx == CMD_WR_SINGLE) begin
                                n_phase = PH_XEND; res.cs_active = 1'b0;
                            end else if (n_left != '0) begin
                                n_phase = PH_WTOK; res.tx_byte = 8'hFC;
                            end else begin
                                n_phase = PH_STOP; res.tx_byte = 8'hFD;
                            end
                        end
                    end
                    PH_STOP: begin
                        n_phase = PH_FBUSY; n_ms = i_cfg.busy_to;
                        res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.cs_active = 1'b1;
                    end
                    PH_FBUSY: begin
                        res.tx_byte = 8'hFF; res.tx_valid = 1'b1;
                        if (rx == 8'h00 && r_ms != '0) res.cs_active = 1'b1;
                        else n_phase = PH_XEND;
                    end
                    default: ;
                endcase
            end else if (i_word.mode == MODE_TICK) begin
                if (r_ms != '0) n_ms = r_ms - 1'b1;
                if (r_ims != '0) n_ims = r_ims - 1'b1;
            end

            // response handling once R1 is known
            if (do_after) begin
                priority case (r_cidx)
                    CMD_GO_IDLE: begin
                        n_phase = PH_X0; res.tx_byte = 8'hFF; res.tx_valid = 1'b1;
                    end
                    CMD_IF_COND, CMD_READ_OCR: begin
                        n_phase = PH_R4; n_bidx = '0; n_reply = '0;
                        res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.cs_active = 1'b1;
                    end
                    CMD_APP: begin
                        do_start = 1'b1; sc_idx = CMD_OP_COND; sc_arg = r_addr;
                    end
                    CMD_OP_COND: begin
                        n_phase = PH_X41; res.tx_byte = 8'hFF; res.tx_valid = 1'b1;
                    end
                    CMD_RD_SINGLE, CMD_RD_MULTI: begin
                        if (n_last != '0) begin
                            n_phase = PH_IDLE; res.done_res = 1'b1; res.status = ST_XFER_ERR;
                        end else begin
                            n_ms = i_cfg.token_to; n_phase = PH_TOK;
                            res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.cs_active = 1'b1;
                        end
                    end
                    CMD_WR_SINGLE, CMD_WR_MULTI: begin
                        if (n_last != '0) begin
                            n_phase = PH_IDLE; res.done_res = 1'b1; res.status = ST_XFER_ERR;
                        end else begin
                            n_phase = PH_WTOK; res.tx_valid = 1'b1; res.cs_active = 1'b1;
                            res.tx_byte = (r_cidx == CMD_WR_SINGLE) ? 8'hFE : 8'hFC;
                        end
                    end
                    default: begin
                        n_phase = PH_XEND; res.tx_byte = 8'hFF; res.tx_valid = 1'b1;
                    end
                endcase
            end

            // command start: wait for the ready byte first
            if (do_start) begin
                n_cidx = sc_idx; n_arg = sc_arg; n_ms = i_cfg.ready_to; n_phase = PH_RDY;
                res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.cs_active = 1'b1;
            end
        end
        res.high_capacity = n_ba;
        res.initialized   = n_rdy;
        res.engine_busy   = (n_phase != PH_IDLE);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_bidx <= '0; r_addr <= '0; r_left <= '0;
            r_arg <= '0; r_reply <= '0; r_cidx <= '0; r_last <= 8'hFF;
            r_poll <= '0; r_ms <= '0; r_ims <= '0; r_ba <= 1'b0; r_rdy <= 1'b0;
        end else begin
            r_phase <= n_phase; r_bidx <= n_bidx; r_addr <= n_addr; r_left <= n_left;
            r_arg <= n_arg; r_reply <= n_reply; r_cidx <= n_cidx; r_last <= n_last;
            r_poll <= n_poll; r_ms <= n_ms; r_ims <= n_ims; r_ba <= n_ba; r_rdy <= n_rdy;
        end
    end

    assign o_word = res;
endmodule
